FILE: rtl/hmm_state_posterior_core_defines.svh
// ----------------------------------------------------------------------------
// hmm_state_posterior_core_defines
// Assertion macros used by the posterior core controller, hsp_ctrl.
// ----------------------------------------------------------------------------
`ifndef HMM_STATE_POSTERIOR_CORE_DEFINES_SVH
`define HMM_STATE_POSTERIOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg
// Types and constants of the HMM state posterior core.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int MAX_STATES_DEF = 16;

  localparam int SAMPLE_W     = 16;
  localparam int PROD_W       = 32;
  localparam int POST_W       = 16;
  localparam int IDX_OUT_W    = 4;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 24;
  localparam int OUT_USER_W   = 2;
  localparam int NUM_STATES_W = 5;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  // Quotient carries one bit above Q0.16 so that exactly 1.0 can saturate.
  localparam int Q_W       = POST_W + 1;
  localparam int DIV_STEPS = Q_W;

  localparam logic [NUM_STATES_W-1:0] NUM_STATES_RST = 5'd16;

  // Register index as seen in paddr bit 2.
  localparam logic REG_NUM_STATES = 1'b0;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_WAIT,
    ST_READ,
    ST_START,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/hsp_divider.sv
// ----------------------------------------------------------------------------
// hsp_divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den,
// saturated to 16 bits. Assumes num <= den, as each product is a term of the sum.
// ----------------------------------------------------------------------------
module hsp_divider #(
  parameter int SUM_W = 36
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hsp_pkg::div_ctl_t           ctl,
  input  logic [hsp_pkg::PROD_W-1:0]  num,
  input  logic [SUM_W-1:0]            den,
  output hsp_pkg::div_sts_t           sts,
  output logic [hsp_pkg::POST_W-1:0]  quot
);

  localparam int STEP_W = $clog2(hsp_pkg::DIV_STEPS);

  logic [SUM_W-1:0]          rem_r, rem_nxt;
  logic [SUM_W-1:0]          den_r;
  logic [hsp_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]         step_r;
  logic                      busy_r;
  logic                      done_r;
  logic [SUM_W:0]            cand;
  logic [SUM_W:0]            diff;
  logic                      ge;
  logic                      last_step;

  // The first step compares the unshifted remainder; that gives the integer bit.
  assign cand      = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign diff      = cand - {1'b0, den_r};
  assign ge        = (cand >= {1'b0, den_r});
  assign last_step = (step_r == STEP_W'(hsp_pkg::DIV_STEPS - 1));

  always_comb begin
    rem_nxt = ge ? diff[SUM_W-1:0] : cand[SUM_W-1:0];
    q_nxt   = {q_r[hsp_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (last_step) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= SUM_W'(num);
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r[hsp_pkg::Q_W-1] ? '1 : q_r[hsp_pkg::POST_W-1:0];

endmodule

FILE: rtl/hsp_ctrl.sv
// ----------------------------------------------------------------------------
// hsp_ctrl
// Product store, running sum and row sequencer: fills the store during a
// row, then reads it back entry by entry through the divider.
// ----------------------------------------------------------------------------
`include "hmm_state_posterior_core_defines.svh"

module hsp_ctrl #(
  parameter int MAX_STATES = hsp_pkg::MAX_STATES_DEF,
  parameter int SUM_W      = hsp_pkg::PROD_W + $clog2(MAX_STATES)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_clear,
  input  logic [hsp_pkg::NUM_STATES_W-1:0]  num_states,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hsp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hsp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic [hsp_pkg::OUT_USER_W-1:0]    out_tuser,
  output hsp_pkg::div_ctl_t                 div_ctl,
  input  hsp_pkg::div_sts_t                 div_sts,
  output logic [hsp_pkg::PROD_W-1:0]        div_num,
  output logic [SUM_W-1:0]                  div_den,
  input  logic [hsp_pkg::POST_W-1:0]        div_quot
);

  localparam int IDX_W = $clog2(MAX_STATES);
  localparam int CNT_W = $clog2(MAX_STATES + 1);
  localparam int KW    = (CNT_W > hsp_pkg::NUM_STATES_W) ? CNT_W : hsp_pkg::NUM_STATES_W;
  localparam int EXT_W = (IDX_W > hsp_pkg::IDX_OUT_W) ? IDX_W : hsp_pkg::IDX_OUT_W;

  hsp_pkg::state_t state_r, state_nxt;

  logic [hsp_pkg::PROD_W-1:0]   mem [MAX_STATES];
  logic [hsp_pkg::PROD_W-1:0]   rd_data_r;
  logic                         mem_we;
  logic                         mem_re;

  logic                         pv_r;
  logic [hsp_pkg::PROD_W-1:0]   prod_r;
  logic [IDX_W-1:0]             pidx_r;

  logic [SUM_W-1:0]             sum_r;
  logic [CNT_W-1:0]             count_r;
  logic [IDX_W-1:0]             ridx_r;
  logic                         last_r;
  logic                         zero_r;

  logic                         out_valid_r;
  logic [hsp_pkg::POST_W-1:0]   out_post_r;
  logic [hsp_pkg::IDX_OUT_W-1:0] out_idx_r;
  logic                         out_last_r;
  logic                         out_seq_r;
  logic                         out_zero_r;

  logic [KW-1:0]                ns_ext;
  logic [KW-1:0]                k_ext;
  logic [CNT_W-1:0]             k;
  logic                         in_acc;
  logic                         complete;
  logic                         row_end;
  logic                         out_load;
  logic [EXT_W-1:0]             ridx_ext;
  logic [hsp_pkg::SAMPLE_W-1:0] alpha;
  logic [hsp_pkg::SAMPLE_W-1:0] beta;

  // Zero states behave as one, and counts past the store depth are clamped.
  always_comb begin
    ns_ext = KW'(num_states);
    if (ns_ext == '0) begin
      k_ext = KW'(1);
    end else if (ns_ext > KW'(MAX_STATES)) begin
      k_ext = KW'(MAX_STATES);
    end else begin
      k_ext = ns_ext;
    end
    k = CNT_W'(k_ext);
  end

  assign alpha    = in_tdata[hsp_pkg::SAMPLE_W-1:0];
  assign beta     = in_tdata[2*hsp_pkg::SAMPLE_W-1:hsp_pkg::SAMPLE_W];
  assign in_acc   = in_tvalid && in_tready;
  assign complete = (CNT_W'(count_r + 1'b1) == k);
  assign row_end  = (CNT_W'(ridx_r) == CNT_W'(k - 1'b1));
  assign ridx_ext = EXT_W'(ridx_r);
  assign mem_we   = pv_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsp_pkg::ST_ACC: begin
        if (in_acc && complete) begin
          state_nxt = hsp_pkg::ST_WAIT;
        end
      end
      hsp_pkg::ST_WAIT:  state_nxt = hsp_pkg::ST_READ;
      hsp_pkg::ST_READ:  state_nxt = hsp_pkg::ST_START;
      hsp_pkg::ST_START: state_nxt = hsp_pkg::ST_DIV;
      hsp_pkg::ST_DIV: begin
        if (out_load) begin
          state_nxt = row_end ? hsp_pkg::ST_ACC : hsp_pkg::ST_READ;
        end
      end
      default: state_nxt = hsp_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    mem_re        = 1'b0;
    div_ctl.start = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      hsp_pkg::ST_ACC:   in_tready = 1'b1;
      hsp_pkg::ST_WAIT:  ;
      hsp_pkg::ST_READ:  mem_re = 1'b1;
      hsp_pkg::ST_START: div_ctl.start = 1'b1;
      hsp_pkg::ST_DIV:   out_load = div_sts.done && (!out_valid_r || out_tready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsp_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Product store: written from the product stage, read only while draining.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pidx_r] <= prod_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[ridx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_r <= alpha * beta;
      pidx_r <= count_r[IDX_W-1:0];
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      ridx_r  <= '0;
    end else if (cfg_clear) begin
      sum_r   <= '0;
      count_r <= '0;
      ridx_r  <= '0;
    end else begin
      if (out_load && row_end) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        if (pv_r) begin
          sum_r <= sum_r + SUM_W'(prod_r);
        end
        if (in_acc) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (state_r == hsp_pkg::ST_WAIT) begin
        ridx_r <= '0;
      end else if (out_load && !row_end) begin
        ridx_r <= ridx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hsp_pkg::ST_START) begin
      zero_r <= (sum_r == '0);
    end
  end

  // Output register lets the next row start filling while a word waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_post_r <= zero_r ? '0 : div_quot;
      out_idx_r  <= ridx_ext[hsp_pkg::IDX_OUT_W-1:0];
      out_last_r <= row_end;
      out_seq_r  <= last_r;
      out_zero_r <= zero_r;
    end
  end

  assign div_num    = rd_data_r;
  assign div_den    = sum_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hsp_pkg::OUT_DATA_W - hsp_pkg::POST_W - hsp_pkg::IDX_OUT_W){1'b0}},
                       out_idx_r, out_post_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_zero_r, out_seq_r};

  `HSP_ASSERT_IMP(a_no_rw_clash, mem_we, !mem_re, "product store read and written together")
  `HSP_ASSERT_IMP(a_div_idle, div_ctl.start, !div_sts.busy, "divider started while busy")
  `HSP_ASSERT_IMP(a_count_bound, state_r == hsp_pkg::ST_ACC, count_r < k, "row count past limit")
  `HSP_ASSERT_NXT(a_row_close, in_acc && complete, !in_tready && pv_r, "row did not close")

endmodule

FILE: rtl/hmm_state_posterior_core.sv
// After the word that completes a row, the sequencer steps through WAIT, READ (store
// read) and START (divider start) into DIV; each further posterior of the row repeats
// READ, START and the bit-serial division (17 quotient bits). No input is taken meanwhile.
// Input words are taken one per cycle while a row fills; the store is not cleared.
// Reset (rst_n, synchronous, active low) clears the row count, the running sum and
// the handshakes, and sets num_states to 16.
// ----------------------------------------------------------------------------
// hmm_state_posterior_core
// HMM state posterior: alpha*beta per state, normalized by the row sum.
// ----------------------------------------------------------------------------
module hmm_state_posterior_core #(
  parameter int MAX_STATES = hsp_pkg::MAX_STATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hsp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [hsp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [hsp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  // Input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hsp_pkg::IN_DATA_W-1:0]   in_tdata,   // alpha_value, beta_value
  input  logic                            in_tlast,   // last_step
  // Result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hsp_pkg::OUT_DATA_W-1:0]  out_tdata,  // posterior, state_index, zero pad
  output logic                            out_tlast,  // last_of_row
  output logic [hsp_pkg::OUT_USER_W-1:0]  out_tuser   // last_in_sequence, zero_sum
);

  localparam int SUM_W = hsp_pkg::PROD_W + $clog2(MAX_STATES);

  logic [hsp_pkg::NUM_STATES_W-1:0] num_states_r;
  logic                             cfg_wr;
  logic                             cfg_hit;
  hsp_pkg::div_ctl_t                div_ctl;
  hsp_pkg::div_sts_t                div_sts;
  logic [hsp_pkg::PROD_W-1:0]       div_num;
  logic [SUM_W-1:0]                 div_den;
  logic [hsp_pkg::POST_W-1:0]       div_quot;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == hsp_pkg::REG_NUM_STATES);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? hsp_pkg::CFG_DATA_W'(num_states_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= hsp_pkg::NUM_STATES_RST;
    end else if (cfg_wr) begin
      num_states_r <= cfg_pwdata[hsp_pkg::NUM_STATES_W-1:0];
    end
  end

  hsp_ctrl #(
    .MAX_STATES (MAX_STATES),
    .SUM_W      (SUM_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_clear  (cfg_wr),
    .num_states (num_states_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .div_ctl    (div_ctl),
    .div_sts    (div_sts),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_quot   (div_quot)
  );

  hsp_divider #(
    .SUM_W (SUM_W)
  ) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quot  (div_quot)
  );

endmodule

FILE: tb/posterior_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posterior_checker
// Watches the configuration port and both stream channels of the posterior
// core. It keeps its own copy of the row state, predicts the normalized
// posteriors of every completed row and compares each result word with the
// oldest prediction.
// ----------------------------------------------------------------------------
module posterior_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hsp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hsp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                           cfg_pready,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hsp_pkg::IN_DATA_W-1:0]  in_tdata,   // alpha_value, beta_value
  input  logic                           in_tlast,   // last_step
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [hsp_pkg::OUT_DATA_W-1:0] out_tdata,  // posterior, state_index, zero pad
  input  logic                           out_tlast,  // last_of_row
  input  logic [hsp_pkg::OUT_USER_W-1:0] out_tuser,  // last_in_sequence, zero_sum
  output int                             fail_count,
  output int                             gamma_pending
);
  import hsp_pkg::*;

  typedef struct packed {
    logic [POST_W-1:0]    posterior;
    logic [IDX_OUT_W-1:0] state_index;
    logic                 last_of_row;
    logic                 last_in_sequence;
    logic                 zero_sum;
  } gamma_word_t;

  gamma_word_t             gamma_q[$];
  logic [PROD_W-1:0]       row_product [MAX_STATES_DEF];
  logic [35:0]             row_sum;
  int unsigned             row_fill;
  logic [NUM_STATES_W-1:0] states_reg;
  int                      errors = 0;

  function automatic int unsigned states_in_use(input logic [NUM_STATES_W-1:0] ns);
    if (ns == 0) return 1;
    if (ns > MAX_STATES_DEF) return MAX_STATES_DEF;
    return ns;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Adds one state's product to the row; a completed row yields one posterior
  // per state, product * 65536 / sum, saturated to 16 bits.
  task automatic accumulate_state(input logic [SAMPLE_W-1:0] alpha,
                                  input logic [SAMPLE_W-1:0] beta,
                                  input logic last_step);
    int unsigned k;
    logic [47:0] quot;
    gamma_word_t g;
    k = states_in_use(states_reg);
    if (row_fill >= k) begin
      row_fill = 0;
      row_sum  = '0;
    end
    row_product[row_fill] = alpha * beta;
    row_sum += {4'h0, row_product[row_fill]};
    row_fill++;
    if (row_fill == k) begin
      for (int i = 0; i < k; i++) begin
        quot = '0;
        if (row_sum != 0) begin
          quot = {row_product[i], 16'h0000} / {12'h000, row_sum};
          if (quot > 48'hFFFF) quot = 48'hFFFF;
        end
        g.posterior        = quot[POST_W-1:0];
        g.state_index      = IDX_OUT_W'(i);
        g.last_of_row      = (i == k - 1);
        g.last_in_sequence = last_step;
        g.zero_sum         = (row_sum == 0);
        gamma_q.push_back(g);
      end
      row_fill = 0;
      row_sum  = '0;
    end
  endtask

  always @(posedge clk) begin
    gamma_word_t seen;
    gamma_word_t want;
    if (!rst_n) begin
      gamma_q.delete();
      row_fill   = 0;
      row_sum    = '0;
      states_reg = NUM_STATES_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.posterior        = out_tdata[POST_W-1:0];
        seen.state_index      = out_tdata[POST_W +: IDX_OUT_W];
        seen.last_of_row      = out_tlast;
        seen.last_in_sequence = out_tuser[0];
        seen.zero_sum         = out_tuser[1];
        if (gamma_q.size() == 0) begin
          report($sformatf("unexpected word: posterior %0d state %0d last %0b seq %0b zero %0b",
                           seen.posterior, seen.state_index, seen.last_of_row,
                           seen.last_in_sequence, seen.zero_sum));
        end else begin
          want = gamma_q.pop_front();
          if (seen.posterior != want.posterior || seen.state_index != want.state_index ||
              seen.last_of_row != want.last_of_row ||
              seen.last_in_sequence != want.last_in_sequence ||
              seen.zero_sum != want.zero_sum) begin
            report($sformatf({"mismatch: expected posterior %0d state %0d last %0b seq %0b",
                              " zero %0b, got %0d %0d %0b %0b %0b"},
                             want.posterior, want.state_index, want.last_of_row,
                             want.last_in_sequence, want.zero_sum,
                             seen.posterior, seen.state_index, seen.last_of_row,
                             seen.last_in_sequence, seen.zero_sum));
          end
        end
      end
      // A write to the state count throws away any partial row.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_NUM_STATES) begin
        states_reg = cfg_pwdata[NUM_STATES_W-1:0];
        row_fill   = 0;
        row_sum    = '0;
      end
      if (in_tvalid && in_tready)
        accumulate_state(in_tdata[SAMPLE_W-1:0], in_tdata[SAMPLE_W +: SAMPLE_W], in_tlast);
    end
    fail_count    <= errors;
    gamma_pending <= gamma_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the HMM state posterior core: a directed run over the value
// extremes and the special rows, then random rows under several state counts
// with random stalls on both channels and one long hold-off of the result
// side. The checker instance predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
  import hsp_pkg::*;

  localparam int IDLE_PCT       = 34;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 240;

  localparam logic [CFG_ADDR_W-1:0] ADDR_NUM_STATES = {REG_NUM_STATES, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

  typedef enum int {FILL_FULL, FILL_SPARSE, FILL_CORNER, FILL_HIGH} fill_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // alpha_value, beta_value
  logic                  in_tlast    = 1'b0; // last_step
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // posterior, state_index, zero pad
  logic                  out_tlast;          // last_of_row
  logic [OUT_USER_W-1:0] out_tuser;          // last_in_sequence, zero_sum

  int fail_count;
  int gamma_pending;
  int hold_requests = 0;
  int quiet_cycles  = 0;
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b0;

  hmm_state_posterior_core DUT (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  posterior_checker u_checker (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .fail_count, .gamma_pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin : result_sink
    int hold_served;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_calm || $urandom_range(0, 99) >= IDLE_PCT) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] sample(input fill_t mode);
    case (mode)
      FILL_SPARSE: begin
        if ($urandom_range(0, 1) == 0) return '0;
        return SAMPLE_W'($urandom_range(1, 255));
      end
      FILL_CORNER: begin
        case ($urandom_range(0, 3))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
      FILL_HIGH: return SAMPLE_W'($urandom_range(65000, 65535));
      default:   return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_state(input logic [SAMPLE_W-1:0] alpha,
                            input logic [SAMPLE_W-1:0] beta,
                            input logic last_step);
    if (!tx_calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {beta, alpha};
    in_tlast  <= last_step;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted posterior has arrived, then lets the core settle
  // before the next step; a partial row yields no posterior to wait for.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (gamma_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [NUM_STATES_W-1:0] ns;
    int unsigned             k;
    int unsigned             rows;
    int unsigned             sent;
    int unsigned             phase;
    fill_t                   mode;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full row at the reset state count, corner values throughout.
    send_state(16'hFFFF, 16'hFFFF, 1'b0);
    for (int i = 1; i < 16; i++)
      send_state(sample(FILL_CORNER), sample(FILL_CORNER), i == 15);
    settle();

    // One state whose product is zero: the sum is zero.
    write_reg(ADDR_NUM_STATES, 32'd1);
    send_state(16'h0000, 16'hFFFF, 1'b1);
    settle();

    // One nonzero product among two states saturates at full scale.
    write_reg(ADDR_NUM_STATES, 32'd2);
    send_state(16'hFFFF, 16'hFFFF, 1'b0);
    send_state(16'h0000, 16'hFFFF, 1'b1);
    settle();

    // A state count of zero behaves as one.
    write_reg(ADDR_NUM_STATES, 32'd0);
    send_state(16'h1234, 16'h4321, 1'b1);
    settle();

    // Above the maximum behaves as the maximum; the partial row is dropped by
    // the next write, while a write outside the register map leaves it alone.
    write_reg(ADDR_NUM_STATES, 32'd31);
    send_state(sample(FILL_FULL), sample(FILL_FULL), 1'b0);
    send_state(sample(FILL_FULL), sample(FILL_FULL), 1'b1);
    settle();
    write_reg(ADDR_NUM_STATES, 32'd3);
    send_state(sample(FILL_FULL), sample(FILL_FULL), 1'b1);
    settle();
    write_reg(ADDR_UNMAPPED, 32'd1);
    send_state(sample(FILL_FULL), sample(FILL_FULL), 1'b0);
    send_state(sample(FILL_FULL), sample(FILL_FULL), 1'b0);
    settle();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       ns = 5'd0;
        1:       ns = NUM_STATES_W'($urandom_range(17, 31));
        2:       ns = 5'd16;
        3:       ns = 5'd1;
        default: ns = NUM_STATES_W'($urandom_range(1, 16));
      endcase
      // The second phase fills whole rows while the result side holds off.
      if (phase == 1) ns = 5'd16;
      tx_calm  = (phase >= 4 && phase < 7);
      rx_calm <= (phase >= 5 && phase < 8);
      write_reg(ADDR_NUM_STATES, CFG_DATA_W'(ns));
      if (phase == 1) hold_requests <= hold_requests + 1;
      k    = (ns == 0) ? 1 : ((ns > MAX_STATES_DEF) ? MAX_STATES_DEF : ns);
      rows = (phase == 1) ? 3 : $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
        mode = fill_t'($urandom_range(0, 3));
        for (int j = 0; j < k; j++)
          send_state(sample(mode), sample(mode), $urandom_range(0, 3) == 0);
        sent += k;
      end
      // Now and then leave a partial row for the next write to discard.
      if (k > 1 && $urandom_range(0, 5) == 0) begin
        for (int j = $urandom_range(1, k - 1); j > 0; j--)
          send_state(sample(FILL_FULL), sample(FILL_FULL), 1'b0);
      end
      settle();
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: hmm_state_posterior_core.f
+incdir+rtl
rtl/hsp_pkg.sv
rtl/hsp_divider.sv
rtl/hsp_ctrl.sv
rtl/hmm_state_posterior_core.sv
tb/posterior_checker.sv
tb/tb.sv
